/* hw/rtl/assert_macros.svh */
// shared assertion macros, clocked on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle implies consequence
`define AEWU_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the following cycle
`define AEWU_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/aewu_pkg.sv */
package aewu_pkg;

  // word layout
  localparam int WORD_W = 32;
  localparam int SLOT_W = 5;
  localparam int CHAN_W = 6;
  localparam int VALUE_W = 13;
  localparam int CNT_W = 32;

  localparam logic [2:0] TYPE_DATA = 3'd0;
  localparam logic [2:0] TYPE_TRAILER = 3'd4;
  localparam logic [WORD_W-1:0] FILLER_WORD = '1;
  localparam logic [VALUE_W-1:0] OVERFLOW_VALUE = 13'd4096;

  // queue between front and back; depth is a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_TRAIL,
    PH_FILL
  } phase_t;

  // one classified word on its way to the back end
  typedef struct packed {
    logic               data_valid;
    logic [CHAN_W-1:0]  channel;
    logic [VALUE_W-1:0] value;
    logic               overflowed;
    logic               event_end;
    logic               slot_mismatch;
    logic               inc_data;
    logic               inc_ovf;
    logic               inc_mism;
  } item_t;

endpackage

/* hw/rtl/aewu_if.sv */
interface aewu_word_if;
  logic                          valid;
  logic                          ready;
  logic [aewu_pkg::WORD_W-1:0]   word;

  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

interface aewu_result_if;
  logic                          valid;
  logic                          ready;
  logic                          data_valid;
  logic [aewu_pkg::CHAN_W-1:0]   channel;
  logic [aewu_pkg::VALUE_W-1:0]  value;
  logic                          overflowed;
  logic                          event_end;
  logic                          slot_mismatch;
  logic [aewu_pkg::CNT_W-1:0]    total_data;
  logic [aewu_pkg::CNT_W-1:0]    overflow_total;
  logic [aewu_pkg::CNT_W-1:0]    mismatch_total;

  modport source(output valid, output data_valid, output channel, output value,
                 output overflowed, output event_end, output slot_mismatch,
                 output total_data, output overflow_total, output mismatch_total,
                 input ready);
  modport sink(input valid, input data_valid, input channel, input value,
               input overflowed, input event_end, input slot_mismatch,
               input total_data, input overflow_total, input mismatch_total,
               output ready);
endinterface

/* hw/rtl/aewu_front.sv */
module aewu_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [aewu_pkg::SLOT_W-1:0] expected_slot,
  aewu_word_if.sink                   words,
  input  logic                        q_full,
  output logic                        push,
  output aewu_pkg::item_t             item
);

  aewu_pkg::phase_t phase;
  aewu_pkg::phase_t phase_next;

  logic [2:0] wtype;
  logic       hdr_match;
  logic       hdr_trl;
  logic       is_filler;
  logic       accept;

  assign words.ready = !q_full;
  assign accept = words.valid && !q_full;
  assign push = accept;

  // field decode shared by all phases
  assign wtype = words.word[26:24];
  assign hdr_match = (words.word[31:27] == expected_slot);
  assign hdr_trl = (wtype == aewu_pkg::TYPE_TRAILER);
  assign is_filler = (words.word == aewu_pkg::FILLER_WORD);

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= aewu_pkg::PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // classify the word against the current phase
  always_comb begin
    logic do_header;
    logic do_after;
    do_header = 1'b0;
    do_after = 1'b0;
    phase_next = phase;
    item = '0;

    case (phase)
      aewu_pkg::PH_IDLE: begin
        do_header = 1'b1;
      end
      aewu_pkg::PH_DATA: begin
        if (wtype == aewu_pkg::TYPE_DATA) begin
          item.inc_data = 1'b1;
          if (!words.word[13]) begin
            item.data_valid = 1'b1;
            item.channel = words.word[21:16];
            if (words.word[12]) begin
              item.inc_ovf = 1'b1;
              item.overflowed = 1'b1;
              item.value = aewu_pkg::OVERFLOW_VALUE;
            end else begin
              item.value = {1'b0, words.word[11:0]};
            end
          end
        end else if (hdr_trl) begin
          item.event_end = 1'b1;
          phase_next = aewu_pkg::PH_TRAIL;
        end else begin
          // event closed without trailer
          item.event_end = 1'b1;
          do_after = 1'b1;
        end
      end
      aewu_pkg::PH_TRAIL: begin
        do_after = !hdr_trl;
      end
      aewu_pkg::PH_FILL: begin
        do_after = 1'b1;
      end
      default: begin
        do_after = 1'b1;
      end
    endcase

    // filler check after an event
    if (do_after) begin
      if (is_filler) begin
        phase_next = aewu_pkg::PH_IDLE;
      end else begin
        do_header = 1'b1;
      end
    end

    // header decode
    if (do_header) begin
      if (!hdr_match) begin
        item.inc_mism = 1'b1;
        item.slot_mismatch = 1'b1;
        phase_next = aewu_pkg::PH_IDLE;
      end else if (hdr_trl) begin
        item.event_end = 1'b1;
        phase_next = aewu_pkg::PH_FILL;
      end else begin
        phase_next = aewu_pkg::PH_DATA;
      end
    end
  end

endmodule

/* hw/rtl/aewu_queue.sv */
module aewu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  aewu_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output aewu_pkg::item_t q_item
);

  aewu_pkg::item_t entries [aewu_pkg::QUEUE_DEPTH];

  logic [aewu_pkg::QPTR_W-1:0] wr_ptr;
  logic [aewu_pkg::QPTR_W-1:0] rd_ptr;
  logic [aewu_pkg::QCNT_W-1:0] count;

  assign full = (count == aewu_pkg::QCNT_W'(aewu_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

/* hw/rtl/aewu_back.sv */
module aewu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  aewu_pkg::item_t q_item,
  output logic            pop,
  aewu_result_if.source   results
);

  logic out_valid;
  logic [aewu_pkg::CNT_W-1:0] data_counter;
  logic [aewu_pkg::CNT_W-1:0] overflow_counter;
  logic [aewu_pkg::CNT_W-1:0] mismatch_counter;
  logic [aewu_pkg::CNT_W-1:0] data_counter_next;
  logic [aewu_pkg::CNT_W-1:0] overflow_counter_next;
  logic [aewu_pkg::CNT_W-1:0] mismatch_counter_next;

  logic                          data_valid;
  logic [aewu_pkg::CHAN_W-1:0]   channel;
  logic [aewu_pkg::VALUE_W-1:0]  value;
  logic                          overflowed;
  logic                          event_end;
  logic                          slot_mismatch;

  // take the next item when the output register is empty or draining
  assign pop = q_valid && (!out_valid || results.ready);

  assign data_counter_next = data_counter + aewu_pkg::CNT_W'(q_item.inc_data);
  assign overflow_counter_next = overflow_counter + aewu_pkg::CNT_W'(q_item.inc_ovf);
  assign mismatch_counter_next = mismatch_counter + aewu_pkg::CNT_W'(q_item.inc_mism);

  // running counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      data_counter <= '0;
      overflow_counter <= '0;
      mismatch_counter <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        data_counter <= data_counter_next;
        overflow_counter <= overflow_counter_next;
        mismatch_counter <= mismatch_counter_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (pop) begin
      data_valid <= q_item.data_valid;
      channel <= q_item.channel;
      value <= q_item.value;
      overflowed <= q_item.overflowed;
      event_end <= q_item.event_end;
      slot_mismatch <= q_item.slot_mismatch;
    end
  end

  assign results.valid = out_valid;
  assign results.data_valid = data_valid;
  assign results.channel = channel;
  assign results.value = value;
  assign results.overflowed = overflowed;
  assign results.event_end = event_end;
  assign results.slot_mismatch = slot_mismatch;
  assign results.total_data = data_counter;
  assign results.overflow_total = overflow_counter;
  assign results.mismatch_total = mismatch_counter;

endmodule

/* hw/rtl/adc_event_word_unpacker_core.sv */
// Decodes an ADC readout stream one 32-bit word per beat: headers checked
// against expected_slot, data words turned into channel/value pairs (4096 on
// overflow, nothing on underflow), trailers closing the event and an all-ones
// filler after it swallowed. Every accepted word gives exactly one result beat
// carrying the running data, overflow and slot-mismatch counts (32-bit,
// wrapping). A word can be accepted every cycle while the queue has room; its
// result beat passes through the queue and then the output register, and is
// held until the sink is ready. The front decoder and the back-end output stage
// are separated by a 4-entry queue, so input stalls only once a stalled result
// sink holds five words: four in the queue and one in the output register. After
// the sink frees a queue entry, input is taken again from the following cycle.
// expected_slot should be written only while no words are in flight.
module adc_event_word_unpacker_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [aewu_pkg::SLOT_W-1:0] cfg_data,
  aewu_word_if.sink                   words,
  aewu_result_if.source               results
);

  logic [aewu_pkg::SLOT_W-1:0] expected_slot;
  logic            push;
  logic            q_full;
  logic            pop;
  logic            q_valid;
  aewu_pkg::item_t push_item;
  aewu_pkg::item_t q_item;

  // slot register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_slot <= '0;
    end else if (cfg_we) begin
      expected_slot <= cfg_data;
    end
  end

  aewu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .expected_slot (expected_slot),
    .words         (words),
    .q_full        (q_full),
    .push          (push),
    .item          (push_item)
  );

  aewu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  aewu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .results (results)
  );

endmodule

/* hw/rtl/aewu_checker.sv */
`include "assert_macros.svh"

module aewu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          data_valid,
  input logic [aewu_pkg::CHAN_W-1:0]   channel,
  input logic [aewu_pkg::VALUE_W-1:0]  value,
  input logic                          overflowed,
  input logic                          event_end,
  input logic                          slot_mismatch,
  input logic [aewu_pkg::CNT_W-1:0]    total_data
);

  // overflow beats carry the fixed overflow value
  `AEWU_CHECK(a_ovf_value, res_valid && overflowed, data_valid && value == aewu_pkg::OVERFLOW_VALUE, "overflow beat without value 4096")

  // plain conversions stay within 12 bits, empty beats carry zero payload
  `AEWU_CHECK(a_value_range, res_valid && !overflowed, value[aewu_pkg::VALUE_W-1] == 1'b0 && (data_valid || (value == '0 && channel == '0)), "bad value on result beat")

  // a data beat never also closes an event or flags a foreign header
  `AEWU_CHECK(a_data_exclusive, res_valid && data_valid, !event_end && !slot_mismatch, "data beat with event or mismatch flag")

  // a stalled beat keeps its count
  `AEWU_CHECK_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(total_data), "stalled result beat changed")

endmodule

bind adc_event_word_unpacker_core aewu_checker u_aewu_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .data_valid    (results.data_valid),
  .channel       (results.channel),
  .value         (results.value),
  .overflowed    (results.overflowed),
  .event_end     (results.event_end),
  .slot_mismatch (results.slot_mismatch),
  .total_data    (results.total_data)
);
